@@ rtl/ile_pkg.sv @@
package ile_pkg;

	// sizes
	localparam int ILE_CAPACITY = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 7;
	localparam int CMD_W        = 3;
	localparam int STAT_W       = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] item_value;
	} ile_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STAT_W-1:0]        status;
	} ile_out_t;

endpackage

@@ rtl/ile_mem.sv @@
module ile_mem #(
	parameter int DEPTH = ile_pkg::ILE_CAPACITY,
	parameter int AW    = 6
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [ile_pkg::DATA_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [ile_pkg::DATA_W-1:0] rd_data
);
	import ile_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/ile_ctrl.sv @@
module ile_ctrl #(
	parameter int CAPACITY = ile_pkg::ILE_CAPACITY,
	parameter int AW       = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ile_pkg::ile_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output ile_pkg::ile_out_t          out_data,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [ile_pkg::DATA_W-1:0] wr_data,
	output logic                       rd_en,
	output logic [AW-1:0]              rd_addr,
	input  logic [ile_pkg::DATA_W-1:0] rd_data
);
	import ile_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW : POS_W;
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_GET   = 3'd1;
	localparam logic [2:0] S_GETW  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     cnt_q, cnt_d;
	logic [AW-1:0]     src_q, src_d;
	logic [AW-1:0]     pos_q, pos_d;
	logic              ins_q, ins_d;
	logic [DATA_W-1:0] val_q;
	ile_out_t          res_q, res_d;
	logic              v_s1;
	logic [AW-1:0]     dst_s1;
	logic              out_valid_q;
	ile_out_t          out_q;

	logic [CW-1:0] pos_x, len_x, pos_eff_x;
	logic          is_ins;
	logic          slot_free;

	assign pos_x     = CW'(in_data.position);
	assign len_x     = CW'(len_q);
	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// decode the beat and plan the work
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		src_d     = src_q;
		pos_d     = pos_q;
		ins_d     = ins_q;
		res_d     = res_q;
		is_ins    = in_data.command inside {CMD_HEAD, CMD_TAIL, CMD_INSERT};
		pos_eff_x = pos_x;
		if (in_data.command == CMD_HEAD) begin
			pos_eff_x = '0;
		end else if (in_data.command == CMD_TAIL) begin
			pos_eff_x = len_x;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_d.read_value = MISS_VALUE;
					res_d.status     = ST_DONE;
					ins_d            = is_ins;
					state_d          = S_FIN;
					case (in_data.command)
						CMD_GET: begin
							if (pos_x < len_x) begin
								pos_d   = AW'(pos_x);
								state_d = S_GET;
							end else begin
								res_d.status = ST_RANGE;
							end
						end
						CMD_HEAD, CMD_TAIL, CMD_INSERT: begin
							if (pos_eff_x > len_x) begin
								res_d.status = ST_RANGE;
							end else if (len_q == CAP_L) begin
								res_d.status = ST_FULL;
							end else begin
								pos_d   = AW'(pos_eff_x);
								cnt_d   = LW'(len_x - pos_eff_x);
								src_d   = AW'(len_x - CW'(1));
								state_d = S_SHIFT;
							end
						end
						CMD_DELETE: begin
							if (pos_x < len_x) begin
								pos_d   = AW'(pos_x);
								cnt_d   = LW'(len_x - pos_x - CW'(1));
								src_d   = AW'(pos_x + CW'(1));
								state_d = S_SHIFT;
							end else begin
								res_d.status = ST_RANGE;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_GET: begin
				state_d = S_GETW;
			end
			S_GETW: begin
				res_d.read_value = rd_data;
				state_d          = S_FIN;
			end
			S_SHIFT: begin
				// one move per cycle: read the source, write it one place over
				if (cnt_q != '0) begin
					cnt_d = cnt_q - LW'(1);
					src_d = ins_q ? src_q - AW'(1) : src_q + AW'(1);
				end else if (!v_s1) begin
					state_d = S_PUT;
				end
			end
			S_PUT: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory port drive
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = src_q;
		wr_en   = 1'b0;
		wr_addr = dst_s1;
		wr_data = rd_data;
		case (state_q)
			S_GET: begin
				rd_en   = 1'b1;
				rd_addr = pos_q;
			end
			S_SHIFT: begin
				rd_en = (cnt_q != '0);
				wr_en = v_s1;
			end
			S_PUT: begin
				wr_en   = ins_q;
				wr_addr = pos_q;
				wr_data = val_q;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			v_s1    <= (state_q == S_SHIFT) && (cnt_q != '0);
			if (state_q == S_PUT) begin
				len_q <= ins_q ? len_q + LW'(1) : len_q - LW'(1);
			end
			if (state_q == S_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		src_q  <= src_d;
		pos_q  <= pos_d;
		ins_q  <= ins_d;
		res_q  <= res_d;
		dst_s1 <= ins_q ? src_q + AW'(1) : src_q - AW'(1);
		if (in_valid && in_ready) begin
			val_q <= in_data.item_value;
		end
		if (state_q == S_FIN && slot_free) begin
			out_q <= res_q;
		end
	end

endmodule

@@ rtl/indexed_list_engine.sv @@
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit values.
// Input channel (in_valid/in_ready/in_data) takes one command beat: get, add
// at head, add at tail, insert at position, delete at position. Output channel
// (out_valid/out_ready/out_data) returns exactly one beat per command: the
// value read (or -1) and a status (done, out of range, list full).
// One command is worked on at a time; in_ready is high only while idle.
// Path from accept to output valid: a rejected or unknown command goes
// straight to S_FIN; a get reads the element memory in S_GET and S_GETW;
// an insert or add runs S_SHIFT, then writes the new value in S_PUT; a
// delete runs S_SHIFT, then shortens the list in S_PUT. In S_FIN the
// result is loaded into the output register.
// Inserts and deletes move
// each entry behind the position by one place, one entry per cycle through
// the single read port and single write port of the element memory.
// The result sits in an output register, so the engine returns to idle once
// it is loaded; if the receiver stalls with the register full, the finished
// result waits and no new command is taken until the register frees.
// Reset empties the list; memory contents are not cleared.
module indexed_list_engine #(
	parameter int CAPACITY = ile_pkg::ILE_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ile_pkg::ile_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ile_pkg::ile_out_t out_data
);
	import ile_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_data;

	// sequencer and result register
	ile_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// element store
	ile_mem #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
